[sv/pnr_pkg.sv]
package pnr_pkg;

  localparam int DATA_W      = 32;
  localparam int WIDE_W      = 64;
  localparam int ITER_W      = 8;
  localparam int STAT_W      = 2;
  localparam int DEGCFG_W    = 3;
  localparam int TOL_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int MAX_DEGREE_DEF = 4;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [DEGCFG_W-1:0] DEGREE_RST   = 3'd2;
  localparam logic [TOL_W-1:0]    TOLERANCE_RST = 31'd66;
  localparam logic [ITER_W-1:0]   MAX_ITER_RST  = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_POLY_DEGREE,
    REG_TOLERANCE,
    REG_MAX_ITER
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CONVERGED  = 2'd0,
    ST_DERIV_ZERO = 2'd1,
    ST_LIMIT      = 2'd2
  } stop_status_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
  } mac_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] result;
  } mac_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat_to32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[DATA_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

[sv/pnr_if.sv]
interface pnr_in_if import pnr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] initial_guess;

  modport source (output valid, output initial_guess, input ready);
  modport sink   (input valid, input initial_guess, output ready);
endinterface

interface pnr_out_if import pnr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] root;
  logic [ITER_W-1:0]        iterations_done;
  logic [STAT_W-1:0]        stop_status;

  modport source (output valid, output root, output iterations_done, output stop_status,
                  input ready);
  modport sink   (input valid, input root, input iterations_done, input stop_status,
                  output ready);
endinterface

interface pnr_cfg_if import pnr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/polynomial_newton_root.sv]
// Newton-Raphson root search on a polynomial of degree up to MAX_DEGREE in signed
// fixed point with FRAC_BITS fraction bits. One guess is taken at a time and in_chan
// stays low until its request is finished. A single multiply-add unit evaluates
// p(x) and p'(x) by Horner steps, and a radix-2 divider forms the Newton step.
// Configuration writes are taken every cycle but must only be issued while idle.
module polynomial_newton_root import pnr_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pnr_in_if.sink     in_chan,
  pnr_out_if.source  out_chan,
  pnr_cfg_if.sink    cfg_chan
);

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_P_ISSUE, S_P_WAIT, S_D_ISSUE, S_D_WAIT,
    S_DIV_CHK, S_DIV_WAIT, S_UPDATE, S_DONE
  } state_t;

  logic signed [DATA_W-1:0] coef_r [MAX_DEGREE+1];
  logic [DEGCFG_W-1:0]      degree_r;
  logic [TOL_W-1:0]         tol_r;
  logic [ITER_W-1:0]        max_iter_r;
  cfg_reg_t                 cfg_idx;

  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] acc_r, acc_nxt;
  logic signed [DATA_W-1:0] fx_r, fx_nxt;
  logic signed [DATA_W-1:0] h_r, h_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic [DEG_W-1:0]         k_r, k_nxt;
  logic [DEG_W-1:0]         deg_r, deg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] root_r, root_nxt;
  logic [ITER_W-1:0]        iter_out_r, iter_out_nxt;
  stop_status_t             stat_r, stat_nxt;
  stop_status_t             stat_out_r, stat_out_nxt;

  logic [DEG_W-1:0]           deg_use;
  logic [DEG_W-1:0]           rd_idx;
  logic signed [DATA_W-1:0]   coef_rd;
  logic signed [DATA_W+DEG_W:0] kprod;
  logic signed [DATA_W-1:0]   kcoef;
  logic signed [DATA_W:0]     diff;
  logic signed [DATA_W-1:0]   nx;
  logic signed [DATA_W:0]     stp;
  logic [DATA_W:0]            stp_abs;

  mac_req_t mac_req;
  mac_rsp_t mac_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pnr_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk (clk),
    .rst_n (rst_n),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  pnr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers
  assign cfg_chan.ready = 1'b1;
  assign cfg_idx = cfg_reg_t'(cfg_chan.index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_DEGREE; i++) begin
        coef_r[i] <= '0;
      end
      degree_r   <= DEGREE_RST;
      tol_r      <= TOLERANCE_RST;
      max_iter_r <= MAX_ITER_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx) inside
        [REG_COEF_0:REG_COEF_4]: begin
          for (int i = 0; i <= MAX_DEGREE; i++) begin
            if (cfg_chan.index == CFG_IDX_W'(i)) begin
              coef_r[i] <= $signed(cfg_chan.data);
            end
          end
        end
        REG_POLY_DEGREE: degree_r   <= cfg_chan.data[DEGCFG_W-1:0];
        REG_TOLERANCE:   tol_r      <= cfg_chan.data[TOL_W-1:0];
        REG_MAX_ITER:    max_iter_r <= cfg_chan.data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign deg_use = (degree_r > DEGCFG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                      : degree_r[DEG_W-1:0];

  // single coefficient read port
  always_comb begin
    unique case (state_r)
      S_P_ISSUE: rd_idx = k_r - 1'b1;
      S_D_ISSUE: rd_idx = k_r;
      default:   rd_idx = deg_r;
    endcase
    coef_rd = coef_r[rd_idx];
    kprod   = $signed({1'b0, rd_idx}) * coef_rd;
    kcoef   = sat_to32(WIDE_W'(kprod));
  end

  always_comb begin
    mac_req.start = (state_r == S_P_ISSUE) || (state_r == S_D_ISSUE);
    mac_req.a     = acc_r;
    mac_req.b     = x_r;
    mac_req.c     = (state_r == S_P_ISSUE) ? coef_rd : kcoef;
    div_req.start = (state_r == S_DIV_CHK) && (acc_r != '0);
    div_req.num   = fx_r;
    div_req.den   = acc_r;
  end

  // x' = sat(x - h), step measured exactly from the saturated x'
  always_comb begin
    diff    = {x_r[DATA_W-1], x_r} - {h_r[DATA_W-1], h_r};
    nx      = sat_to32(WIDE_W'(diff));
    stp     = {nx[DATA_W-1], nx} - {x_r[DATA_W-1], x_r};
    stp_abs = stp[DATA_W] ? (~stp + 1'b1) : stp;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    fx_nxt        = fx_r;
    h_nxt         = h_r;
    iter_nxt      = iter_r;
    k_nxt         = k_r;
    deg_nxt       = deg_r;
    root_nxt      = root_r;
    iter_out_nxt  = iter_out_r;
    stat_nxt      = stat_r;
    stat_out_nxt  = stat_out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          x_nxt     = in_chan.initial_guess;
          iter_nxt  = '0;
          deg_nxt   = deg_use;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (iter_r >= max_iter_r) begin
          stat_nxt  = ST_LIMIT;
          state_nxt = S_DONE;
        end else if (deg_r == '0) begin
          stat_nxt  = ST_DERIV_ZERO;
          state_nxt = S_DONE;
        end else begin
          acc_nxt   = coef_rd;
          k_nxt     = deg_r;
          state_nxt = S_P_ISSUE;
        end
      end
      S_P_ISSUE: state_nxt = S_P_WAIT;
      S_P_WAIT: begin
        if (mac_rsp.done) begin
          if (k_r == DEG_W'(1)) begin
            fx_nxt  = mac_rsp.result;
            acc_nxt = kcoef;
            k_nxt   = deg_r - 1'b1;
            state_nxt = (deg_r == DEG_W'(1)) ? S_DIV_CHK : S_D_ISSUE;
          end else begin
            acc_nxt   = mac_rsp.result;
            k_nxt     = k_r - 1'b1;
            state_nxt = S_P_ISSUE;
          end
        end
      end
      S_D_ISSUE: state_nxt = S_D_WAIT;
      S_D_WAIT: begin
        if (mac_rsp.done) begin
          acc_nxt = mac_rsp.result;
          if (k_r == DEG_W'(1)) begin
            state_nxt = S_DIV_CHK;
          end else begin
            k_nxt     = k_r - 1'b1;
            state_nxt = S_D_ISSUE;
          end
        end
      end
      S_DIV_CHK: begin
        if (acc_r == '0) begin
          stat_nxt  = ST_DERIV_ZERO;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          h_nxt     = div_rsp.quo;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        x_nxt    = nx;
        iter_nxt = iter_r + 1'b1;
        if (stp_abs < {2'b00, tol_r}) begin
          stat_nxt  = ST_CONVERGED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          root_nxt      = x_r;
          iter_out_nxt  = iter_r;
          stat_out_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    fx_r       <= fx_nxt;
    h_r        <= h_nxt;
    iter_r     <= iter_nxt;
    k_r        <= k_nxt;
    deg_r      <= deg_nxt;
    root_r     <= root_nxt;
    iter_out_r <= iter_out_nxt;
    stat_r     <= stat_nxt;
    stat_out_r <= stat_out_nxt;
  end

  assign in_chan.ready            = (state_r == S_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.root            = root_r;
  assign out_chan.iterations_done = iter_out_r;
  assign out_chan.stop_status     = stat_out_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mac_rsp.busy && div_rsp.busy))
    else $error("multiply unit and divider active together");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.den != '0))
    else $error("division started with zero derivative");

  a_conv_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.stop_status == ST_CONVERGED)) |->
      (out_chan.iterations_done != '0))
    else $error("converged request reports no completed step");

endmodule

[sv/pnr_mac.sv]
module pnr_mac import pnr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  logic                     v1_r;
  logic                     done_r;
  logic signed [WIDE_W-1:0] prod_r;
  logic signed [DATA_W-1:0] c_r;
  logic signed [DATA_W-1:0] res_r;

  logic signed [WIDE_W-1:0] shifted;
  logic signed [DATA_W-1:0] prod_sat;
  logic signed [DATA_W:0]   sum;

  // floor rounding of the product, then saturate, add, saturate
  always_comb begin
    shifted  = prod_r >>> FRAC_BITS;
    prod_sat = sat_to32(shifted);
    sum      = {prod_sat[DATA_W-1], prod_sat} + {c_r[DATA_W-1], c_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      done_r <= v1_r;
    end
    if (req.start) begin
      prod_r <= WIDE_W'(req.a) * WIDE_W'(req.b);
      c_r    <= req.c;
    end
    if (v1_r) begin
      res_r <= sat_to32(WIDE_W'(sum));
    end
  end

  assign rsp.busy   = v1_r;
  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

[sv/pnr_div.sv]
module pnr_div import pnr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t                  state_r, state_nxt;
  logic [DATA_W:0]          rem_r, rem_nxt;
  logic [NUM_W-1:0]         quo_r, quo_nxt;
  logic [DATA_W-1:0]        den_r, den_nxt;
  logic                     neg_r, neg_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     done_r, done_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;

  logic [DATA_W:0]          trial;
  logic                     ge;
  logic                     hi_any;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    trial     = {rem_r[DATA_W-1:0], quo_r[NUM_W-1]};
    ge        = trial >= {1'b0, den_r};
    hi_any    = |quo_r[NUM_W-1:DATA_W];
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          rem_nxt   = '0;
          quo_nxt   = {mag32(req.num), {FRAC_BITS{1'b0}}};
          den_nxt   = mag32(req.den);
          neg_nxt   = req.num[DATA_W-1] ^ req.den[DATA_W-1];
          cnt_nxt   = CNT_W'(NUM_W - 1);
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
        quo_nxt = {quo_r[NUM_W-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = D_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      D_FIN: begin
        if (neg_r) begin
          if (hi_any || (quo_r[DATA_W-1] && |quo_r[DATA_W-2:0])) begin
            res_nxt = 32'sh8000_0000;
          end else begin
            res_nxt = $signed(~quo_r[DATA_W-1:0] + 1'b1);
          end
        end else begin
          if (hi_any || quo_r[DATA_W-1]) begin
            res_nxt = 32'sh7FFF_FFFF;
          end else begin
            res_nxt = $signed(quo_r[DATA_W-1:0]);
          end
        end
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.busy = (state_r != D_IDLE);
  assign rsp.done = done_r;
  assign rsp.quo  = res_r;

endmodule
